// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define SVL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SVL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/svl_pkg.sv -----
// ----------------------------------------------------------------------------
// svl_pkg
// Types and codes shared by the sorted value list.
// ----------------------------------------------------------------------------
package svl_pkg;

  localparam int VAL_W = 32;
  localparam int CMD_W = 2;
  localparam int STS_W = 2;
  localparam int CNT_W = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY     = 2'd2;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_RD,
    S_DEL_CMP,
    S_SH_RD,
    S_SH_WR,
    S_FINISH
  } state_t;

endpackage

// ----- hw/rtl/sorted_value_list.sv -----
// ----------------------------------------------------------------------------
// sorted_value_list
// Ascending list of signed 32-bit values in a single-port-write memory,
// walked one entry at a time by a small sequencer with one comparator.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | in_command, in_operand_value
// out     | output    | out_valid / out_ready | out_status, out_smallest_value,
//         |           |                       | out_is_empty, out_entry_count
//
// An insert walks down from the back, moving each entry that is equal or greater
// up one slot until it finds the place for the new value; a delete scans from
// the front for the value and then shifts every later entry down; a pop shifts
// every entry down. A refused or empty command goes straight to the result. Each
// step uses the one memory read port and the single comparator.
// Reset clears the count, sequencer and output valid; memory contents are
// not cleared. in_ready is low while an item is in work; a held result in
// the output register does not stop the next item from being accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_value_list #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [svl_pkg::CMD_W-1:0]           in_command,
  input  logic signed [svl_pkg::VAL_W-1:0]    in_operand_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [svl_pkg::STS_W-1:0]           out_status,
  output logic signed [svl_pkg::VAL_W-1:0]    out_smallest_value,
  output logic                                out_is_empty,
  output logic [svl_pkg::CNT_W-1:0]           out_entry_count
);
  import svl_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  // State
  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic signed [VAL_W-1:0]   op_r;
  logic [STS_W-1:0]          status_r, status_nxt;
  logic signed [VAL_W-1:0]   head_r;

  // Memory
  logic signed [VAL_W-1:0]   mem [CAPACITY];
  logic signed [VAL_W-1:0]   rd_data_r;
  logic [CW-1:0]             rd_idx;
  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;
  logic signed [VAL_W-1:0]   mem_wdata;

  // Output register
  logic                      out_valid_r;
  logic [STS_W-1:0]          out_status_r;
  logic signed [VAL_W-1:0]   out_smallest_r;
  logic                      out_is_empty_r;
  logic [CNT_W-1:0]          out_count_r;
  logic                      out_load;

  logic                      accept;
  logic                      ge_hit, eq_hit, gt_hit;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  // Shared comparator on the last read entry
  assign ge_hit = (rd_data_r >= op_r);
  assign eq_hit = (rd_data_r == op_r);
  assign gt_hit = (rd_data_r > op_r);

  // Next state and sequencer registers
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = STS_OK;
          idx_nxt    = '0;
          case (in_command)
            CMD_INSERT: begin
              if (count_r >= CAP_C) begin
                status_nxt = STS_FULL;
                state_nxt  = S_FINISH;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_INS_RD;
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                status_nxt = STS_EMPTY;
                state_nxt  = S_FINISH;
              end else begin
                state_nxt = S_DEL_RD;
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                status_nxt = STS_EMPTY;
                state_nxt  = S_FINISH;
              end else begin
                state_nxt = S_SH_RD;
              end
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          count_nxt = count_r + ONE_C;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (ge_hit) begin
          idx_nxt   = idx_r - ONE_C;
          state_nxt = S_INS_RD;
        end else begin
          count_nxt = count_r + ONE_C;
          state_nxt = S_FINISH;
        end
      end
      S_DEL_RD: begin
        if (idx_r == count_r) begin
          status_nxt = STS_NOT_FOUND;
          state_nxt  = S_FINISH;
        end else begin
          state_nxt = S_DEL_CMP;
        end
      end
      S_DEL_CMP: begin
        if (eq_hit) begin
          state_nxt = S_SH_RD;
        end else if (gt_hit) begin
          status_nxt = STS_NOT_FOUND;
          state_nxt  = S_FINISH;
        end else begin
          idx_nxt   = idx_r + ONE_C;
          state_nxt = S_DEL_RD;
        end
      end
      S_SH_RD: begin
        if (idx_r + ONE_C == count_r) begin
          count_nxt = count_r - ONE_C;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        idx_nxt   = idx_r + ONE_C;
        state_nxt = S_SH_RD;
      end
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r[IW-1:0];
    mem_wdata = op_r;
    rd_idx    = idx_r;
    case (state_r)
      S_INS_RD: begin
        rd_idx = idx_r - ONE_C;
        if (idx_r == '0) begin
          mem_we = 1'b1;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (ge_hit) begin
          mem_wdata = rd_data_r;
        end
      end
      S_SH_RD: rd_idx = idx_r + ONE_C;
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Entry storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_idx[IW-1:0]];
  end

  // Copy of the front entry
  always_ff @(posedge clk) begin
    if (mem_we && (mem_waddr == '0)) begin
      head_r <= mem_wdata;
    end
  end

  // Operand, status and index
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_operand_value;
    end
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r   <= status_r;
      out_smallest_r <= (count_r == '0) ? '0 : head_r;
      out_is_empty_r <= (count_r == '0);
      out_count_r    <= CNT_W'(count_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_smallest_value = out_smallest_r;
  assign out_is_empty       = out_is_empty_r;
  assign out_entry_count    = out_count_r;

  // Checks
  `SVL_ASSERT(a_count_bound, count_r <= CAP_C, "entry count above capacity")
  `SVL_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready right after accept")
  `SVL_ASSERT_NEXT(a_idle_count_held, state_r == S_IDLE, $stable(count_r),
    "count moved while idle")
  `SVL_ASSERT(a_empty_zero, !(out_valid_r && out_is_empty_r) || (out_smallest_r == '0),
    "empty result with nonzero front value")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted value list. A queue-based model of the
// ascending list predicts status, front value, empty flag and count for every
// accepted command. A short directed opening is followed by random phases
// that fill, churn and drain the list, with random idling on both channels,
// one long output hold-off and pauses that let the list go quiet.
// ----------------------------------------------------------------------------
module tb;
  import svl_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int TAIL       = 4 * CAPACITY + 16;
  localparam int QUIET_MAX  = 2000;
  localparam int SEGMENTS   = 13;
  localparam int SEG_ITEMS  = 40;
  localparam int HOLD_LEN   = 150;

  typedef logic [CMD_W-1:0]        cmd_t;
  typedef logic signed [VAL_W-1:0] value_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    value_t           smallest;
    logic             is_empty;
    logic [CNT_W-1:0] count;
  } list_result_t;

  // Ascending list model plus the queue of results it has predicted
  class sorted_list_model;
    value_t       stored[$];
    list_result_t expected_results[$];
    int           errors;
    int           checked;
    int           cmd_seen[4];
    int           status_seen[4];

    // Apply one accepted command and queue the result it should produce
    function void note_command(cmd_t c, value_t v);
      list_result_t r;
      int pos;
      pos = 0;
      r.status = STS_OK;
      case (c)
        CMD_INSERT: begin
          if (stored.size() >= CAPACITY) begin
            r.status = STS_FULL;
          end else begin
            // goes ahead of the first entry that is equal or greater
            while (pos < stored.size() && stored[pos] < v) pos++;
            stored.insert(pos, v);
          end
        end
        CMD_DELETE: begin
          if (stored.size() == 0) begin
            r.status = STS_EMPTY;
          end else begin
            while (pos < stored.size() && stored[pos] != v) pos++;
            if (pos == stored.size()) r.status = STS_NOT_FOUND;
            else stored.delete(pos);
          end
        end
        CMD_POP: begin
          if (stored.size() == 0) r.status = STS_EMPTY;
          else void'(stored.pop_front());
        end
        default: ;
      endcase
      r.is_empty = (stored.size() == 0);
      r.smallest = r.is_empty ? '0 : stored[0];
      r.count    = CNT_W'(stored.size());
      cmd_seen[c]++;
      status_seen[r.status]++;
      expected_results.push_back(r);
    endfunction

    // Compare one delivered result against the oldest prediction
    function void check_result(list_result_t got);
      list_result_t exp;
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: status %0d count %0d",
               got.status, got.count);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      checked++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.smallest !== exp.smallest) begin
        $error("smallest_value: expected %0d, got %0d", exp.smallest, got.smallest);
        errors++;
      end
      if (got.is_empty !== exp.is_empty) begin
        $error("is_empty: expected %0d, got %0d", exp.is_empty, got.is_empty);
        errors++;
      end
      if (got.count !== exp.count) begin
        $error("entry_count: expected %0d, got %0d", exp.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  cmd_t             in_command = CMD_INSERT;
  value_t           in_operand_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [STS_W-1:0] out_status;
  value_t           out_smallest_value;
  logic             out_is_empty;
  logic [CNT_W-1:0] out_entry_count;

  sorted_list_model board;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int hold_len = 0;
  int quiet_cycles = 0;

  sorted_value_list #(.CAPACITY(CAPACITY)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_operand_value   (in_operand_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_smallest_value (out_smallest_value),
    .out_is_empty       (out_is_empty),
    .out_entry_count    (out_entry_count)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Offer one item and hold it until the list takes it
  task automatic send_item(input cmd_t c, input value_t v);
    int gap;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= c;
    in_operand_value <= v;
    do @(posedge clk); while (!in_ready);
    board.note_command(c, v);
  endtask

  // Stop offering until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.expected_results.size() != 0);
  endtask

  function automatic cmd_t pick_command(int insert_pct);
    if ($urandom_range(0, 99) < insert_pct) return CMD_INSERT;
    if ($urandom_range(0, 9) < 6) return CMD_DELETE;
    return CMD_POP;
  endfunction

  // Small values make duplicates; stored values make deletes hit
  function automatic value_t pick_value(cmd_t c);
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = board.stored.size();
    if (c == CMD_DELETE && n > 0 && r < 60) return board.stored[$urandom_range(0, n - 1)];
    if (r < 35) return value_t'($urandom_range(0, 16)) - 8;
    if (r < 55 && n > 0) return board.stored[$urandom_range(0, n - 1)];
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return -1;
        default: return 0;
      endcase
    end
    return value_t'($urandom());
  endfunction

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      board.check_result('{out_status, out_smallest_value, out_is_empty, out_entry_count});
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    cmd_t c;
    value_t v;
    int insert_pct;
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, extremes, front insert/delete, duplicates, full
    send_item(CMD_POP, 0);
    send_item(CMD_DELETE, 7);
    send_item(CMD_INSERT, 0);
    send_item(CMD_INSERT, 32'sh7fffffff);
    send_item(CMD_INSERT, 32'sh80000000);
    send_item(CMD_INSERT, -1);
    send_item(CMD_INSERT, 0);
    send_item(CMD_DELETE, 5);
    send_item(CMD_DELETE, 32'sh80000000);
    send_item(CMD_DELETE, 0);
    send_item(CMD_POP, 32'sh5a5a5a5a);
    for (int i = 0; i < CAPACITY - 2; i++) begin
      send_item(CMD_INSERT, (i % 2) ? value_t'($urandom()) : value_t'(100 - 7 * i));
    end
    send_item(CMD_INSERT, 3);
    wait_drained();

    // Random phases; the last ones run with no idling at all
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 80;
        1: insert_pct = 50;
        default: insert_pct = 20;
      endcase
      tx_idle = (seg < SEGMENTS - 2) && ($urandom_range(0, 3) != 0);
      rx_idle = (seg < SEGMENTS - 2) && ($urandom_range(0, 3) != 0);
      if (seg == 3) begin
        insert_pct = 60;
        tx_idle    = 1'b0;
        hold_len   = HOLD_LEN;
      end
      repeat (SEG_ITEMS) begin
        c = pick_command(insert_pct);
        v = pick_value(c);
        send_item(c, v);
      end
      if (seg == 5 || seg == 9) wait_drained();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (board.expected_results.size() != 0);
    repeat (TAIL) @(posedge clk);

    $display("Ran %0d inserts, %0d deletes, %0d pops; %0d results checked",
             board.cmd_seen[CMD_INSERT], board.cmd_seen[CMD_DELETE],
             board.cmd_seen[CMD_POP], board.checked);
    $display("Statuses predicted: ok %0d, full %0d, empty %0d, not found %0d",
             board.status_seen[STS_OK], board.status_seen[STS_FULL],
             board.status_seen[STS_EMPTY], board.status_seen[STS_NOT_FOUND]);
    if (board.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
